[sv/ffu_pkg.sv]
// Shared types and constants for the first-fit unit allocator.
// Used by ffu_ctrl, ffu_datapath and first_fit_unit_allocator_unit; no dependencies.
package ffu_pkg;

  // Result codes on the status port.
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_OWNER    = 2'd1;
  localparam logic [1:0] ST_NO_SPACE = 2'd2;

  // Request modes.
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // Reset value of the unit count register.
  localparam logic [8:0] TOTAL_UNITS_RESET = 9'd256;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_FILL   = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_en;
    logic load;
    logic scan_en;
    logic fill_start;
    logic fill_en;
    logic out_load;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic clear_done;
    logic scan_done;
    logic fill_go;
    logic fill_done;
  } stat_t;

endpackage

[sv/ffu_ctrl.sv]
// Controller state machine of the first-fit unit allocator.
// Depends on ffu_pkg; drives ffu_datapath through cmd_t and reads stat_t.
module ffu_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output ffu_pkg::cmd_t  cmd,
  input  ffu_pkg::stat_t stat
);
  import ffu_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;
  logic   can_load;

  assign in_stall = (state != S_IDLE);
  assign can_load = !out_valid || !out_stall;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_done) begin
          if (stat.fill_go) begin
            cmd.fill_start = 1'b1;
            state_next     = S_FILL;
          end else begin
            state_next = S_RESULT;
          end
        end
      end
      S_FILL: begin
        cmd.fill_en = 1'b1;
        if (stat.fill_done) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (can_load) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // A finished word stays until taken; a new one loads once the slot is free.
  assign out_valid_next = cmd.out_load | (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[sv/ffu_datapath.sv]
// Datapath of the first-fit unit allocator: owner map memory, scan counters,
// window search and result register. Depends on ffu_pkg; driven by ffu_ctrl.
module ffu_datapath #(
  parameter int UNITS   = 256,
  parameter int ID_BITS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  ffu_pkg::cmd_t  cmd,
  output ffu_pkg::stat_t stat,
  input  logic           cfg_we,
  input  logic [8:0]     total_units,
  input  logic           mode,
  input  logic [7:0]     owner_id,
  input  logic [8:0]     request_size,
  output logic [1:0]     status
);
  import ffu_pkg::*;

  localparam int ADDR_W = (UNITS > 1) ? $clog2(UNITS) : 1;
  localparam int CNT_W  = $clog2(UNITS + 1);
  localparam int CMP_W  = (CNT_W > 9) ? CNT_W : 9;
  localparam logic [CNT_W-1:0] UNITS_CNT  = CNT_W'(UNITS);
  localparam logic [CNT_W-1:0] LAST_CNT   = CNT_W'(UNITS - 1);
  localparam logic [CMP_W-1:0] UNITS_CMP  = CMP_W'(UNITS);
  localparam int ENTRY_W = ID_BITS + 1;

  // Each entry holds the used flag on top and the owner below it.
  logic [ENTRY_W-1:0] map_mem [UNITS];

  logic [8:0]         units_limit;
  logic               req_mode;
  logic [ID_BITS-1:0] req_id;
  logic [CMP_W-1:0]   req_size;
  logic [CMP_W-1:0]   lim;
  logic [CNT_W-1:0]   addr;
  logic               rd_pend;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               present;
  logic               found;
  logic [CMP_W-1:0]   run;
  logic [ADDR_W-1:0]  first;
  logic [CMP_W-1:0]   remain;

  logic               hit;
  logic               in_window;
  logic [CMP_W-1:0]   run_next;
  logic               fits;
  logic [CMP_W-1:0]   first_wide;
  logic [CMP_W-1:0]   lim_next;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [1:0]         status_next;

  assign hit        = rd_pend && rd_data[ENTRY_W-1] && (rd_data[ID_BITS-1:0] == req_id);
  assign in_window  = (CMP_W'(rd_addr) < lim);
  assign run_next   = rd_data[ENTRY_W-1] ? '0 : run + CMP_W'(1);
  assign fits       = rd_pend && !found && in_window && (req_size != '0)
                      && (run_next == req_size);
  assign first_wide = CMP_W'(rd_addr) + CMP_W'(1) - req_size;
  assign lim_next   = (CMP_W'(units_limit) > UNITS_CMP) ? UNITS_CMP : CMP_W'(units_limit);

  assign stat.clear_done = (addr == LAST_CNT);
  assign stat.scan_done  = (addr == UNITS_CNT) && !rd_pend;
  assign stat.fill_go    = (req_mode == MODE_ALLOC) && !present && found;
  assign stat.fill_done  = (remain == CMP_W'(1));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_addr;
    mem_wdata = {1'b0, req_id};
    if (cmd.clear_en) begin
      mem_we    = 1'b1;
      mem_waddr = addr[ADDR_W-1:0];
      mem_wdata = '0;
    end else if (cmd.fill_en) begin
      mem_we    = 1'b1;
      mem_waddr = addr[ADDR_W-1:0];
      mem_wdata = {1'b1, req_id};
    end else if (cmd.scan_en && (req_mode == MODE_RELEASE) && hit) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    if (req_mode == MODE_RELEASE) begin
      status_next = present ? ST_DONE : ST_OWNER;
    end else if (present) begin
      status_next = ST_OWNER;
    end else begin
      status_next = found ? ST_DONE : ST_NO_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) map_mem[mem_waddr] <= mem_wdata;
    if (cmd.scan_en && (addr < UNITS_CNT)) rd_data <= map_mem[addr[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      units_limit <= TOTAL_UNITS_RESET;
    end else if (cfg_we) begin
      units_limit <= total_units;
    end
  end

  // The fill start comes in the last scan cycle, so it takes the address first.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr    <= '0;
      rd_pend <= 1'b0;
    end else if (cmd.clear_en) begin
      addr <= addr + CNT_W'(1);
    end else if (cmd.load) begin
      addr    <= '0;
      rd_pend <= 1'b0;
    end else if (cmd.fill_start) begin
      addr <= CNT_W'(first);
    end else if (cmd.scan_en) begin
      rd_pend <= (addr < UNITS_CNT);
      if (addr < UNITS_CNT) addr <= addr + CNT_W'(1);
    end else if (cmd.fill_en) begin
      addr <= addr + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode <= mode;
      req_id   <= ID_BITS'(owner_id);
      req_size <= CMP_W'(request_size);
      lim      <= lim_next;
      present  <= 1'b0;
      found    <= 1'b0;
      run      <= '0;
    end else if (cmd.scan_en && rd_pend) begin
      if (hit) present <= 1'b1;
      if (!found && in_window) run <= run_next;
      // The first window that reaches the requested size wins.
      if (fits) begin
        found <= 1'b1;
        first <= first_wide[ADDR_W-1:0];
      end
    end
    if (cmd.scan_en && (addr < UNITS_CNT)) rd_addr <= addr[ADDR_W-1:0];
    if (cmd.fill_start) begin
      remain <= req_size;
    end else if (cmd.fill_en) begin
      remain <= remain - CMP_W'(1);
    end
    if (cmd.out_load) status <= status_next;
  end

endmodule

[sv/first_fit_unit_allocator_unit.sv]
// Top level of the first-fit unit allocator.
// Depends on ffu_pkg and instantiates ffu_ctrl and ffu_datapath.
//
// First-fit allocator over UNITS memory units, kept as an owner map with one
// used flag and one owner id per unit. After reset the block clears the map
// and takes no request until that is done; the configuration port is open at
// all times. Each request makes one pass over the whole map through its single
// read port: the pass checks whether the owner holds a block, looks for the
// lowest free window of request_size units below total_units, and for a
// release frees the owner's units as it goes. A successful allocate then
// writes its request_size units, one unit per cycle, and the result word then
// loads once the output slot is free. The next request is taken only once the
// result word is loaded, so a new request is not accepted while one is in
// flight, and a result word still held by out_stall keeps the next result
// word, and so the next request, waiting.
// Status is 0 for done, 1 when the owner already holds a block (allocate) or
// holds nothing (release), and 2 when no window fits.
module first_fit_unit_allocator_unit #(
  parameter int UNITS   = 256,
  parameter int ID_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] total_units,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       mode,
  input  logic [7:0] owner_id,
  input  logic [8:0] request_size,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status
);
  import ffu_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  ffu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  ffu_datapath #(
    .UNITS   (UNITS),
    .ID_BITS (ID_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_valid & cfg_ready),
    .total_units  (total_units),
    .mode         (mode),
    .owner_id     (owner_id),
    .request_size (request_size),
    .status       (status)
  );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Testbench for first_fit_unit_allocator_unit: directed and random allocate and
// release requests, checked word by word against an owner map kept here.
// Depends on ffu_pkg and the allocator RTL only.
module tb;
  import ffu_pkg::*;

  localparam int UNITS = 256;

  typedef struct {
    logic       op;
    logic [7:0] id;
    logic [8:0] size;
    logic [1:0] want;
  } alloc_request_t;

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [8:0] total_units;
  logic       in_valid;
  logic       in_stall;
  logic       mode;
  logic [7:0] owner_id;
  logic [8:0] request_size;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] status;

  // Owner map as the testbench sees it, updated when each request word is taken.
  logic       unit_used [UNITS];
  logic [7:0] unit_holder [UNITS];
  logic [8:0] unit_limit;

  alloc_request_t pending_status[$];
  int             mismatches;
  bit             no_idle;

  first_fit_unit_allocator_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .total_units  (total_units),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .owner_id     (owner_id),
    .request_size (request_size),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_wait();
    return no_idle ? 0 : int'($urandom_range(0, 4));
  endfunction

  function automatic logic holds_block(logic [7:0] id);
    int i;
    for (i = 0; i < UNITS; i++)
      if (unit_used[i] && unit_holder[i] == id)
        return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [1:0] serve_request(logic op, logic [7:0] id, logic [8:0] size);
    int lim;
    int run;
    int i;
    int j;
    if (op == MODE_RELEASE) begin
      if (!holds_block(id))
        return ST_OWNER;
      for (i = 0; i < UNITS; i++)
        if (unit_used[i] && unit_holder[i] == id)
          unit_used[i] = 1'b0;
      return ST_DONE;
    end
    if (holds_block(id))
      return ST_OWNER;
    lim = (unit_limit > UNITS) ? UNITS : unit_limit;
    if (size == 0 || size > lim)
      return ST_NO_SPACE;
    run = 0;
    for (i = 0; i < lim; i++) begin
      run = unit_used[i] ? 0 : run + 1;
      if (run == size) begin
        for (j = i + 1 - size; j <= i; j++) begin
          unit_used[j] = 1'b1;
          unit_holder[j] = id;
        end
        return ST_DONE;
      end
    end
    return ST_NO_SPACE;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < 40)
      $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Called at a falling edge and returns at one; in_valid stays high so that a
  // back-to-back word does not lower and raise it in the same step.
  task automatic issue_request(logic op, logic [7:0] id, logic [8:0] size);
    int gap;
    alloc_request_t r;
    gap = pick_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= op;
    owner_id     <= id;
    request_size <= size;
    do @(posedge clk); while (in_stall);
    r.op   = op;
    r.id   = id;
    r.size = size;
    r.want = serve_request(op, id, size);
    pending_status.push_back(r);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_status.size() != 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_units(logic [8:0] value);
    cfg_valid   <= 1'b1;
    total_units <= value;
    do @(posedge clk); while (!cfg_ready);
    unit_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_owner_and_first_fit();
    issue_request(MODE_ALLOC, 8'd0, 9'd256);
    issue_request(MODE_ALLOC, 8'd0, 9'd1);
    issue_request(MODE_ALLOC, 8'd255, 9'd1);
    issue_request(MODE_RELEASE, 8'd255, 9'd0);
    issue_request(MODE_RELEASE, 8'd0, 9'd511);
    issue_request(MODE_ALLOC, 8'd7, 9'd0);
    issue_request(MODE_ALLOC, 8'd7, 9'd300);
    issue_request(MODE_ALLOC, 8'd1, 9'd3);
    issue_request(MODE_ALLOC, 8'd2, 9'd5);
    issue_request(MODE_ALLOC, 8'd3, 9'd2);
    issue_request(MODE_RELEASE, 8'd2, 9'd0);
    // The hole left by owner 2 is one unit too short for owner 4.
    issue_request(MODE_ALLOC, 8'd4, 9'd6);
    issue_request(MODE_ALLOC, 8'd5, 9'd5);
    issue_request(MODE_RELEASE, 8'd1, 9'd0);
    issue_request(MODE_RELEASE, 8'd4, 9'd0);
  endtask

  task automatic test_unit_count();
    wait_idle();
    write_units(9'd1);
    issue_request(MODE_ALLOC, 8'd9, 9'd1);
    issue_request(MODE_ALLOC, 8'd10, 9'd1);
    wait_idle();
    write_units(9'd0);
    issue_request(MODE_ALLOC, 8'd10, 9'd1);
    issue_request(MODE_ALLOC, 8'd9, 9'd1);
    issue_request(MODE_RELEASE, 8'd9, 9'd0);
    wait_idle();
    write_units(9'd256);
    issue_request(MODE_ALLOC, 8'd11, 9'd200);
    wait_idle();
    // Shrinking leaves owner 11 in place above the new limit.
    write_units(9'd8);
    issue_request(MODE_ALLOC, 8'd11, 9'd1);
    issue_request(MODE_ALLOC, 8'd12, 9'd1);
    issue_request(MODE_RELEASE, 8'd11, 9'd0);
    wait_idle();
    write_units(9'd511);
    issue_request(MODE_ALLOC, 8'd13, 9'd256);
    issue_request(MODE_RELEASE, 8'd13, 9'd0);
  endtask

  task automatic test_random_traffic();
    int         ph;
    int         n;
    int         cap;
    int         roll;
    logic [8:0] setting;
    logic [7:0] id;
    logic [8:0] size;
    logic       op;
    logic       held;
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: setting = 9'd256;
        1: setting = 9'd64;
        2: setting = 9'd17;
        3: setting = 9'd2;
        default: setting = 9'($urandom_range(1, 256));
      endcase
      wait_idle();
      write_units(setting);
      no_idle = (ph == 4);
      for (n = 0; n < 190; n++) begin
        // A small owner pool keeps blocks live so that owner checks and
        // releases mostly find something.
        if ($urandom_range(0, 4) == 0)
          id = 8'($urandom_range(0, 255));
        else
          id = 8'($urandom_range(0, 15));
        held = holds_block(id);
        if ($urandom_range(0, 99) < 85)
          op = held ? MODE_RELEASE : MODE_ALLOC;
        else
          op = held ? MODE_ALLOC : MODE_RELEASE;
        cap = (unit_limit > UNITS) ? UNITS : unit_limit;
        if (cap == 0)
          cap = 8;
        roll = int'($urandom_range(0, 99));
        if (roll < 70)
          size = 9'($urandom_range(1, cap / 4 + 1));
        else if (roll < 96)
          size = 9'($urandom_range(1, cap));
        else
          size = 9'($urandom_range(0, 511));
        issue_request(op, id, size);
      end
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    alloc_request_t r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        report_mismatch($sformatf("status word %0d with no request pending", status));
      end else begin
        r = pending_status.pop_front();
        if (status !== r.want)
          report_mismatch($sformatf("status %0d, expected %0d for %s of owner %0d size %0d",
                                    status, r.want, (r.op == MODE_RELEASE) ? "release" : "allocate",
                                    r.id, r.size));
      end
    end
  end

  initial begin : result_sink
    int k;
    out_stall = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      k = pick_wait();
      out_stall <= (k != 0);
      do @(posedge clk); while (!out_valid);
      if (k != 0) begin
        repeat (k - 1) @(posedge clk);
        @(negedge clk);
        out_stall <= 1'b0;
        do @(posedge clk); while (!out_valid);
      end
      @(negedge clk);
    end
  end

  initial begin
    int i;
    clk          = 1'b0;
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    total_units  = '0;
    in_valid     = 1'b0;
    mode         = MODE_ALLOC;
    owner_id     = '0;
    request_size = '0;
    mismatches   = 0;
    no_idle      = 1'b0;
    unit_limit   = TOTAL_UNITS_RESET;
    for (i = 0; i < UNITS; i++) begin
      unit_used[i]   = 1'b0;
      unit_holder[i] = '0;
    end
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    test_owner_and_first_fit();
    test_unit_count();
    test_random_traffic();
    wait_idle();
    repeat (UNITS + 8) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("timeout with %0d status words outstanding", pending_status.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
